### hdl/tqpm_pkg.sv
// ----------------------------------------------------------------------------
// tqpm_pkg: shared types and rule tables for the triangle point mapper
// Word types of both channels and the Dunavant tables of orders 1 to 4,
// abscissae in unsigned Q1.30 and weights in signed Q2.30.
// ----------------------------------------------------------------------------
package tqpm_pkg;

	localparam int RULE_POINTS_MAX = 6;
	localparam int PT_W            = $clog2(RULE_POINTS_MAX);

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef struct packed {
		logic               func;
		logic [12:0]        node_number;
		logic signed [31:0] node_x;
		logic signed [31:0] node_y;
		logic [12:0]        corner_a;
		logic [12:0]        corner_b;
		logic [12:0]        corner_c;
		logic [3:0]         rule_order;
	} job_word_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [63:0] point_weight;
		logic               last_point;
	} point_word_t;

	// Index of the final point of each rule.
	function automatic logic [PT_W-1:0] rule_last(input logic [1:0] sel);
		logic [PT_W-1:0] r;
		case (sel)
			2'd0:    r = PT_W'(0);
			2'd1:    r = PT_W'(2);
			2'd2:    r = PT_W'(3);
			default: r = PT_W'(5);
		endcase
		return r;
	endfunction

	function automatic logic [30:0] rule_xi(input logic [1:0] sel, input logic [PT_W-1:0] k);
		logic [30:0] r;
		case ({sel, k})
			{2'd0, 3'd0}: r = 31'd357913941;
			{2'd1, 3'd0}: r = 31'd178956971;
			{2'd1, 3'd1}: r = 31'd178956971;
			{2'd1, 3'd2}: r = 31'd715827883;
			{2'd2, 3'd0}: r = 31'd357913941;
			{2'd2, 3'd1}: r = 31'd214748365;
			{2'd2, 3'd2}: r = 31'd214748365;
			{2'd2, 3'd3}: r = 31'd644245094;
			{2'd3, 3'd0}: r = 31'd478833546;
			{2'd3, 3'd1}: r = 31'd478833546;
			{2'd3, 3'd2}: r = 31'd116074732;
			{2'd3, 3'd3}: r = 31'd98329211;
			{2'd3, 3'd4}: r = 31'd98329211;
			{2'd3, 3'd5}: r = 31'd877083403;
			default:      r = 31'd0;
		endcase
		return r;
	endfunction

	function automatic logic [30:0] rule_eta(input logic [1:0] sel, input logic [PT_W-1:0] k);
		logic [30:0] r;
		case ({sel, k})
			{2'd0, 3'd0}: r = 31'd357913941;
			{2'd1, 3'd0}: r = 31'd178956971;
			{2'd1, 3'd1}: r = 31'd715827883;
			{2'd1, 3'd2}: r = 31'd178956971;
			{2'd2, 3'd0}: r = 31'd357913941;
			{2'd2, 3'd1}: r = 31'd214748365;
			{2'd2, 3'd2}: r = 31'd644245094;
			{2'd2, 3'd3}: r = 31'd214748365;
			{2'd3, 3'd0}: r = 31'd478833546;
			{2'd3, 3'd1}: r = 31'd116074732;
			{2'd3, 3'd2}: r = 31'd478833546;
			{2'd3, 3'd3}: r = 31'd98329211;
			{2'd3, 3'd4}: r = 31'd877083403;
			{2'd3, 3'd5}: r = 31'd98329211;
			default:      r = 31'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] rule_w(input logic [1:0] sel,
		input logic [PT_W-1:0] k);
		logic signed [31:0] r;
		case ({sel, k})
			{2'd0, 3'd0}: r = 32'sd1073741824;
			{2'd1, 3'd0}: r = 32'sd357913941;
			{2'd1, 3'd1}: r = 32'sd357913941;
			{2'd1, 3'd2}: r = 32'sd357913941;
			{2'd2, 3'd0}: r = -32'sd603979776;
			{2'd2, 3'd1}: r = 32'sd559240533;
			{2'd2, 3'd2}: r = 32'sd559240533;
			{2'd2, 3'd3}: r = 32'sd559240533;
			{2'd3, 3'd0}: r = 32'sd239854156;
			{2'd3, 3'd1}: r = 32'sd239854156;
			{2'd3, 3'd2}: r = 32'sd239854156;
			{2'd3, 3'd3}: r = 32'sd118059786;
			{2'd3, 3'd4}: r = 32'sd118059786;
			{2'd3, 3'd5}: r = 32'sd118059786;
			default:      r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/triangle_quadrature_point_mapper.sv
// ----------------------------------------------------------------------------
// triangle_quadrature_point_mapper: Dunavant quadrature points of a triangle
// Keeps mesh node coordinates in a node memory and maps the points of the
// order 1 to 4 rule onto a triangle, with weights scaled by det/2.
// ----------------------------------------------------------------------------
// A load word (func 0) writes one node's Q16.16 x,y into the node memory in
// the cycle it is taken; node numbers 0 or above NODE_COUNT are dropped. A
// triangle word (func 1) fetches its three corners through the one read port
// of the node memory one after the other, forms the Jacobian determinant, and
// then sends 1, 3, 4 or 6 point words (orders 1 to 4, any other order as 4),
// the final one flagged by last_point. A triangle steps through the corner
// reads and the determinant (S_RD_A to S_DET), then once per point through
// the shared multiply, sum and round path (S_MUL, S_SUM, S_RND, S_OUT); a
// stall holds the sequencer. The next word is taken once the last point sits
// in the output register.
// The node memory is not cleared at reset: a corner must name a node that was
// loaded, while a corner number 0 or above NODE_COUNT reads as (0, 0).
// ----------------------------------------------------------------------------
module triangle_quadrature_point_mapper #(
	parameter int NODE_COUNT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_stall,
	input  tqpm_pkg::job_word_t   job,
	output logic                  point_valid,
	input  logic                  point_stall,
	output tqpm_pkg::point_word_t point
);
	import tqpm_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int IW = ((AW > 13) ? AW : 13) + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_CAP_C, S_DIFF, S_PROD, S_DET,
		S_MUL, S_SUM, S_RND, S_OUT
	} state_t;

	function automatic logic node_ok(input logic [12:0] n);
		return (n != 13'd0) && (IW'(n) <= IW'(NODE_COUNT));
	endfunction

	function automatic logic [AW-1:0] node_idx(input logic [12:0] n);
		logic [IW-1:0] e;
		e = IW'(n) - IW'(1);
		return e[AW-1:0];
	endfunction

	state_t             state_q;
	logic [1:0]         sel_q;
	logic [PT_W-1:0]    k_q;
	logic               point_valid_q;
	point_word_t        point_q;

	logic [AW-1:0]      idx_a_q, idx_b_q, idx_c_q;
	logic               ok_a_q, ok_b_q, ok_c_q;

	logic [63:0]        mem [NODE_COUNT];
	logic [63:0]        rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;

	logic signed [31:0] xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;
	logic signed [32:0] dxb_q, dyb_q, dxc_q, dyc_q;
	logic signed [65:0] p_q, q_q;
	logic signed [66:0] det_q;

	logic [30:0]        xi, eta, n1;
	logic signed [31:0] w;
	logic [PT_W-1:0]    k_last;

	logic signed [63:0] mxa_q, mxb_q, mxc_q, mya_q, myb_q, myc_q;
	logic signed [66:0] wlo_q;
	logic signed [64:0] whi_q;
	logic signed [63:0] sx_q, sy_q;
	logic signed [98:0] sw_q;
	logic signed [33:0] rx_q, ry_q;
	logic signed [67:0] rw_q;

	logic               job_take, out_free, last_k;
	logic [1:0]         ord_sel;
	point_word_t        pt_next;

	assign job_stall   = (state_q != S_IDLE);
	assign job_take    = job_valid && !job_stall;
	assign out_free    = !point_valid_q || !point_stall;
	assign point_valid = point_valid_q;
	assign point       = point_q;

	assign mem_we  = job_take && !job.func && node_ok(job.node_number);
	assign ord_sel = (job.rule_order != 4'd0 && job.rule_order <= 4'd4) ?
		2'(job.rule_order - 4'd1) : 2'd3;

	assign xi     = rule_xi(sel_q, k_q);
	assign eta    = rule_eta(sel_q, k_q);
	assign w      = rule_w(sel_q, k_q);
	assign n1     = ONE_Q30 - xi - eta;
	assign k_last = rule_last(sel_q);
	assign last_k = (k_q == k_last);

	always_comb begin
		case (state_q)
			S_RD_B:  rd_addr = idx_b_q;
			S_RD_C:  rd_addr = idx_c_q;
			default: rd_addr = idx_a_q;
		endcase
	end

	// Writes happen only while idle, so a corner read never meets a write in flight.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[node_idx(job.node_number)] <= {job.node_y, job.node_x};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		pt_next = '0;
		if (rx_q > 34'sh0_7FFF_FFFF) begin
			pt_next.point_x = 32'sh7FFF_FFFF;
		end else if (rx_q < 34'sh3_8000_0000) begin
			pt_next.point_x = 32'sh8000_0000;
		end else begin
			pt_next.point_x = rx_q[31:0];
		end
		if (ry_q > 34'sh0_7FFF_FFFF) begin
			pt_next.point_y = 32'sh7FFF_FFFF;
		end else if (ry_q < 34'sh3_8000_0000) begin
			pt_next.point_y = 32'sh8000_0000;
		end else begin
			pt_next.point_y = ry_q[31:0];
		end
		if (rw_q > 68'sh0_7FFF_FFFF_FFFF_FFFF) begin
			pt_next.point_weight = 64'sh7FFF_FFFF_FFFF_FFFF;
		end else if (rw_q < 68'shF_8000_0000_0000_0000) begin
			pt_next.point_weight = 64'sh8000_0000_0000_0000;
		end else begin
			pt_next.point_weight = rw_q[63:0];
		end
		pt_next.last_point = last_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sel_q         <= 2'd0;
			k_q           <= '0;
			point_valid_q <= 1'b0;
			point_q       <= '0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				point_q       <= pt_next;
				point_valid_q <= 1'b1;
			end else if (point_valid_q && !point_stall) begin
				point_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_take && job.func) begin
						sel_q   <= ord_sel;
						k_q     <= '0;
						state_q <= S_RD_A;
					end
				end
				S_RD_A:  state_q <= S_RD_B;
				S_RD_B:  state_q <= S_RD_C;
				S_RD_C:  state_q <= S_CAP_C;
				S_CAP_C: state_q <= S_DIFF;
				S_DIFF:  state_q <= S_PROD;
				S_PROD:  state_q <= S_DET;
				S_DET:   state_q <= S_MUL;
				S_MUL:   state_q <= S_SUM;
				S_SUM:   state_q <= S_RND;
				S_RND:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (last_k) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + PT_W'(1);
							state_q <= S_MUL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			idx_a_q <= node_idx(job.corner_a);
			idx_b_q <= node_idx(job.corner_b);
			idx_c_q <= node_idx(job.corner_c);
			ok_a_q  <= node_ok(job.corner_a);
			ok_b_q  <= node_ok(job.corner_b);
			ok_c_q  <= node_ok(job.corner_c);
		end
		case (state_q)
			S_RD_B: begin
				xa_q <= ok_a_q ? rd_data_q[31:0] : 32'sd0;
				ya_q <= ok_a_q ? rd_data_q[63:32] : 32'sd0;
			end
			S_RD_C: begin
				xb_q <= ok_b_q ? rd_data_q[31:0] : 32'sd0;
				yb_q <= ok_b_q ? rd_data_q[63:32] : 32'sd0;
			end
			S_CAP_C: begin
				xc_q <= ok_c_q ? rd_data_q[31:0] : 32'sd0;
				yc_q <= ok_c_q ? rd_data_q[63:32] : 32'sd0;
			end
			S_DIFF: begin
				dxb_q <= 33'(xb_q) - 33'(xa_q);
				dyb_q <= 33'(yb_q) - 33'(ya_q);
				dxc_q <= 33'(xc_q) - 33'(xa_q);
				dyc_q <= 33'(yc_q) - 33'(ya_q);
			end
			S_PROD: begin
				p_q <= dxb_q * dyc_q;
				q_q <= dxc_q * dyb_q;
			end
			S_DET: begin
				det_q <= 67'(p_q) - 67'(q_q);
			end
			S_MUL: begin
				mxa_q <= $signed({1'b0, n1}) * xa_q;
				mxb_q <= $signed({1'b0, xi}) * xb_q;
				mxc_q <= $signed({1'b0, eta}) * xc_q;
				mya_q <= $signed({1'b0, n1}) * ya_q;
				myb_q <= $signed({1'b0, xi}) * yb_q;
				myc_q <= $signed({1'b0, eta}) * yc_q;
				// The determinant is split into an unsigned low and a signed high part.
				wlo_q <= $signed({1'b0, det_q[33:0]}) * w;
				whi_q <= $signed(det_q[66:34]) * w;
			end
			S_SUM: begin
				sx_q <= mxa_q + mxb_q + mxc_q;
				sy_q <= mya_q + myb_q + myc_q;
				sw_q <= $signed({whi_q, 34'd0}) + 99'(wlo_q);
			end
			S_RND: begin
				// Adding half minus one for negative values rounds half away from zero.
				rx_q <= 34'((sx_q + 64'sd536870912 - $signed({63'd0, sx_q[63]})) >>> 30);
				ry_q <= 34'((sy_q + 64'sd536870912 - $signed({63'd0, sy_q[63]})) >>> 30);
				rw_q <= 68'((sw_q + 99'sd1073741824 - $signed({98'd0, sw_q[98]})) >>> 31);
			end
			default: ;
		endcase
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_stall && job.func |=> state_q == S_RD_A)
		else $error("triangle word did not start the corner reads");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> k_q <= k_last)
		else $error("point index ran past the end of the rule");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free && last_k |=>
			point_valid_q && point_q.last_point && state_q == S_IDLE)
		else $error("final point did not close the triangle");

	a_det_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) || (state_q == S_RND) || (state_q == S_OUT) |-> $stable(det_q))
		else $error("determinant changed during the point loop");

endmodule
